// ===== hw/rtl/jdcal_pkg.sv =====
package jdcal_pkg;

  // Width of the day number and of the cutover register.
  localparam int unsigned DAY_BITS = 23;

  // Reset value of the cutover register: 15 October 1582.
  localparam int unsigned CUTOVER_RESET = 2299161;

  // Number of register stages between the input and the output word.
  localparam int unsigned NUM_STAGES = 12;

  // Century correction: p = floor((4Z + ALPHA_OFFSET) / ALPHA_DIV) is alpha + 52,
  // which keeps the dividend non-negative for any cutover.
  localparam int unsigned ALPHA_OFFSET = 128179;
  localparam int unsigned ALPHA_DIV    = 146097;
  localparam int unsigned NA_W         = DAY_BITS + 3;
  localparam int unsigned QA_W         = DAY_BITS - 14;
  localparam int unsigned PA_W         = NA_W + QA_W;
  localparam int unsigned REM_A_W      = 19;
  localparam logic [QA_W-1:0] ALPHA_M  = QA_W'((64'd1 << NA_W) / 64'd146097);

  // B = A + 1524, folded with the constants of the correction.
  localparam int unsigned B_W       = DAY_BITS + 1;
  localparam int unsigned B_GREG_ADD = 1486;
  localparam int unsigned B_JUL_ADD  = 1524;

  // C = floor((20B - 2442) / 7305).
  localparam int unsigned C_SCALE  = 20;
  localparam int unsigned C_OFFSET = 2442;
  localparam int unsigned YEAR_DIV = 7305;
  localparam int unsigned NC_W     = DAY_BITS + 6;
  localparam int unsigned C_W      = DAY_BITS - 6;
  localparam int unsigned PC_W     = NC_W + C_W;
  localparam int unsigned REM_C_W  = 14;
  localparam logic [C_W-1:0] C_M   = C_W'((64'd1 << NC_W) / 64'd7305);

  // D = B - floor(1461C / 4), always within 123..488.
  localparam int unsigned D_W        = 9;
  localparam int unsigned DAYS_4YEAR = 1461;
  localparam int unsigned DP_W       = D_W + 2;

  // E = floor(1000D / 30601), always within 4..15.
  localparam int unsigned E_W       = 4;
  localparam int unsigned E_SCALE   = 1000;
  localparam int unsigned MONTH_DIV = 30601;
  localparam int unsigned E_S       = 19;
  localparam int unsigned E_MK      = ((1 << E_S) / MONTH_DIV) * E_SCALE;
  localparam int unsigned EP_W      = D_W + 15;
  localparam int unsigned REM_E_W   = 16;

  // January and February (E above 13) roll into the next year.
  localparam int unsigned E_YEAR_WRAP = 13;
  localparam int unsigned YEAR_BASE_HI = 4715;
  localparam int unsigned YEAR_BASE_LO = 4716;

  // Time of day.
  localparam int unsigned FRAC_W      = 32;
  localparam int unsigned SEC_PER_DAY = 86400;
  localparam int unsigned SEC_W       = 17;
  localparam int unsigned T_W         = FRAC_W + SEC_W;
  localparam int unsigned SEC_PER_HR  = 3600;
  localparam int unsigned HR_M        = (1 << SEC_W) / SEC_PER_HR;
  localparam int unsigned HP_W        = SEC_W + 6;
  localparam int unsigned HREM_W      = 13;
  localparam int unsigned MREM_W      = 12;
  localparam int unsigned SEC_PER_MIN = 60;
  localparam int unsigned MIN_M       = (1 << MREM_W) / SEC_PER_MIN;
  localparam int unsigned MP_W        = MREM_W + 7;
  localparam int unsigned SREM_W      = 7;

  typedef struct packed {
    logic [DAY_BITS-1:0] z;
    logic                greg;
    logic [NA_W-1:0]     na;
    logic [QA_W-1:0]     qa;
    logic [REM_A_W-1:0]  ra;
    logic [B_W-1:0]      b;
    logic [NC_W-1:0]     nc;
    logic [C_W-1:0]      qc;
    logic [REM_C_W-1:0]  rc;
    logic [D_W-1:0]      d;
    logic [E_W-1:0]      qe;
    logic [REM_E_W-1:0]  re;
    logic [SEC_W-1:0]    secs;
    logic [15:0]         sub_second;
    logic [4:0]          hour;
    logic [HREM_W-1:0]   hr;
    logic [MREM_W-1:0]   mrem;
    logic [5:0]          minute;
    logic [SREM_W-1:0]   sr;
    logic [5:0]          second;
    logic [15:0]         year;
    logic [3:0]          month;
    logic [4:0]          day_of_month;
  } pipe_t;

  // floor(30601 * e / 1000) for every month code.
  function automatic logic [D_W-1:0] month_start(input logic [E_W-1:0] e);
    logic [D_W-1:0] r;
    unique case (e)
      4'd0:    r = 9'd0;
      4'd1:    r = 9'd30;
      4'd2:    r = 9'd61;
      4'd3:    r = 9'd91;
      4'd4:    r = 9'd122;
      4'd5:    r = 9'd153;
      4'd6:    r = 9'd183;
      4'd7:    r = 9'd214;
      4'd8:    r = 9'd244;
      4'd9:    r = 9'd275;
      4'd10:   r = 9'd306;
      4'd11:   r = 9'd336;
      4'd12:   r = 9'd367;
      4'd13:   r = 9'd397;
      4'd14:   r = 9'd428;
      4'd15:   r = 9'd459;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

// ===== hw/rtl/julian_day_to_calendar_date.sv =====
// Converts a Julian day, given as its whole day number (floor of JD + 0.5) and a
// 32-bit binary fraction of the day since midnight, into the astronomical year,
// month, day of month, hour, minute, whole second and a 16-bit fraction of the
// second. Days at or after the cutover register get the Gregorian century
// correction, earlier days stay Julian; the register resets to 2299161 and may be
// written at any time the block holds no word. The block is a twelve-stage
// pipeline: it takes one word in every cycle unless a stall holds it; each word
// passes stages 0 to 11 in order and its result is held in the last stage until
// the output side takes it. Each stage holds its own valid bit and a stage moves
// on when the stage after it is empty or moving, so a stalled output only fills
// the pipeline from the back and bubbles are squeezed out. Every constant
// division is a reciprocal multiplication followed by a single correction step,
// spread over three stages; the date and time-of-day paths run side by side in
// the same stages.
module julian_day_to_calendar_date (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          gregorian_cutover_day_we_i,
  input  logic [jdcal_pkg::DAY_BITS-1:0] gregorian_cutover_day_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [jdcal_pkg::DAY_BITS-1:0] day_number_i,
  input  logic [31:0]                   day_fraction_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic signed [15:0]            year_o,
  output logic [3:0]                    month_o,
  output logic [4:0]                    day_of_month_o,
  output logic [4:0]                    hour_o,
  output logic [5:0]                    minute_o,
  output logic [5:0]                    second_o,
  output logic [15:0]                   sub_second_o
);
  import jdcal_pkg::*;

  logic [DAY_BITS-1:0]   cut_q;
  logic [NUM_STAGES-1:0] valid_q, valid_d;
  logic [NUM_STAGES-1:0] load, take;
  pipe_t                 pipe_q [NUM_STAGES];
  pipe_t                 pipe_d [NUM_STAGES];

  // Arithmetic feeding the stage registers.
  logic [NA_W-1:0]  na_in;
  logic [PA_W-1:0]  prod_a;
  logic [T_W-1:0]   prod_t;
  logic [HP_W-1:0]  prod_h;
  logic [NC_W-1:0]  nc_in;
  logic [PC_W-1:0]  prod_c;
  logic [MP_W-1:0]  prod_m;
  logic [DP_W-1:0]  prod_d;
  logic [EP_W-1:0]  prod_e;

  // Cutover register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cut_q <= DAY_BITS'(CUTOVER_RESET);
    end else if (gregorian_cutover_day_we_i) begin
      cut_q <= gregorian_cutover_day_i;
    end
  end

  // A stage loads when it is empty or its word leaves in the same cycle.
  always_comb begin
    take[NUM_STAGES-1] = out_ready_i;
    for (int k = NUM_STAGES - 1; k >= 0; k--) begin
      load[k] = ~valid_q[k] | take[k];
      if (k > 0) begin
        take[k-1] = load[k];
      end
    end
  end

  assign in_ready_o = load[0];

  always_comb begin
    for (int k = 0; k < NUM_STAGES; k++) begin
      if (load[k]) begin
        valid_d[k] = (k == 0) ? in_valid_i : valid_q[k-1];
      end else begin
        valid_d[k] = valid_q[k];
      end
    end
  end

  assign na_in  = {day_number_i, 2'b00} + NA_W'(ALPHA_OFFSET);
  assign prod_a = PA_W'(na_in) * PA_W'(ALPHA_M);
  assign prod_t = T_W'(day_fraction_i) * T_W'(SEC_PER_DAY);
  assign prod_h = HP_W'(pipe_q[0].secs) * HP_W'(HR_M);
  assign nc_in  = NC_W'(pipe_q[3].b) * NC_W'(C_SCALE) - NC_W'(C_OFFSET);
  assign prod_c = PC_W'(nc_in) * PC_W'(C_M);
  assign prod_m = MP_W'(pipe_q[3].mrem) * MP_W'(MIN_M);
  assign prod_d = DP_W'(pipe_q[6].qc) * DP_W'(DAYS_4YEAR);
  assign prod_e = EP_W'(pipe_q[7].d) * EP_W'(E_MK);

  always_comb begin
    for (int k = 1; k < NUM_STAGES; k++) begin
      pipe_d[k] = pipe_q[k-1];
    end

    // Stage 0: alpha quotient estimate, cutover test, seconds of the day.
    pipe_d[0]            = '0;
    pipe_d[0].z          = day_number_i;
    pipe_d[0].greg       = (day_number_i >= cut_q);
    pipe_d[0].na         = na_in;
    pipe_d[0].qa         = QA_W'(prod_a >> NA_W);
    pipe_d[0].secs       = prod_t[T_W-1:FRAC_W];
    pipe_d[0].sub_second = prod_t[FRAC_W-1:FRAC_W-16];

    // Stage 1: remainder of the alpha estimate, hour estimate.
    pipe_d[1].ra   = pipe_q[0].na[REM_A_W-1:0]
                     - REM_A_W'(pipe_q[0].qa) * REM_A_W'(ALPHA_DIV);
    pipe_d[1].hour = 5'(prod_h >> SEC_W);

    // Stage 2: the alpha estimate is at most one short; the remainder tells. Hour remainder.
    if (pipe_q[1].ra >= REM_A_W'(ALPHA_DIV)) begin
      pipe_d[2].qa = pipe_q[1].qa + QA_W'(1);
    end
    pipe_d[2].hr = HREM_W'(pipe_q[1].secs) - HREM_W'(pipe_q[1].hour) * HREM_W'(SEC_PER_HR);

    // Stage 3: B, with the century correction where the day is Gregorian; hour correction.
    if (pipe_q[2].greg) begin
      pipe_d[3].b = B_W'(pipe_q[2].z) + B_W'(pipe_q[2].qa) - B_W'(pipe_q[2].qa >> 2)
                    + B_W'(B_GREG_ADD);
    end else begin
      pipe_d[3].b = B_W'(pipe_q[2].z) + B_W'(B_JUL_ADD);
    end
    if (pipe_q[2].hr >= HREM_W'(SEC_PER_HR)) begin
      pipe_d[3].hour = pipe_q[2].hour + 5'd1;
      pipe_d[3].mrem = MREM_W'(pipe_q[2].hr - HREM_W'(SEC_PER_HR));
    end else begin
      pipe_d[3].mrem = MREM_W'(pipe_q[2].hr);
    end

    // Stage 4: year-count estimate, minute estimate.
    pipe_d[4].nc     = nc_in;
    pipe_d[4].qc     = C_W'(prod_c >> NC_W);
    pipe_d[4].minute = 6'(prod_m >> MREM_W);

    // Stage 5: remainders.
    pipe_d[5].rc = pipe_q[4].nc[REM_C_W-1:0]
                   - REM_C_W'(pipe_q[4].qc) * REM_C_W'(YEAR_DIV);
    pipe_d[5].sr = SREM_W'(pipe_q[4].mrem)
                   - SREM_W'(pipe_q[4].minute) * SREM_W'(SEC_PER_MIN);

    // Stage 6: corrections give C, minute and second.
    if (pipe_q[5].rc >= REM_C_W'(YEAR_DIV)) begin
      pipe_d[6].qc = pipe_q[5].qc + C_W'(1);
    end
    if (pipe_q[5].sr >= SREM_W'(SEC_PER_MIN)) begin
      pipe_d[6].minute = pipe_q[5].minute + 6'd1;
      pipe_d[6].second = 6'(pipe_q[5].sr - SREM_W'(SEC_PER_MIN));
    end else begin
      pipe_d[6].second = 6'(pipe_q[5].sr);
    end

    // Stage 7: D is small, so only the low bits of B and 1461C matter.
    pipe_d[7].d = pipe_q[6].b[D_W-1:0] - prod_d[DP_W-1:2];

    // Stage 8: month-code estimate.
    pipe_d[8].qe = E_W'(prod_e >> E_S);

    // Stage 9: its remainder.
    pipe_d[9].re = REM_E_W'(pipe_q[8].d) * REM_E_W'(E_SCALE)
                   - REM_E_W'(pipe_q[8].qe) * REM_E_W'(MONTH_DIV);

    // Stage 10: E.
    if (pipe_q[9].re >= REM_E_W'(MONTH_DIV)) begin
      pipe_d[10].qe = pipe_q[9].qe + E_W'(1);
    end

    // Stage 11: calendar fields.
    pipe_d[11].day_of_month = 5'(pipe_q[10].d - month_start(pipe_q[10].qe));
    if (pipe_q[10].qe > E_W'(E_YEAR_WRAP)) begin
      pipe_d[11].month = pipe_q[10].qe - 4'(E_YEAR_WRAP);
      pipe_d[11].year  = 16'(pipe_q[10].qc) - 16'(YEAR_BASE_HI);
    end else begin
      pipe_d[11].month = pipe_q[10].qe - 4'd1;
      pipe_d[11].year  = 16'(pipe_q[10].qc) - 16'(YEAR_BASE_LO);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < NUM_STAGES; k++) begin
      if (load[k]) begin
        pipe_q[k] <= pipe_d[k];
      end
    end
  end

  assign out_valid_o    = valid_q[NUM_STAGES-1];
  assign year_o         = $signed(pipe_q[NUM_STAGES-1].year);
  assign month_o        = pipe_q[NUM_STAGES-1].month;
  assign day_of_month_o = pipe_q[NUM_STAGES-1].day_of_month;
  assign hour_o         = pipe_q[NUM_STAGES-1].hour;
  assign minute_o       = pipe_q[NUM_STAGES-1].minute;
  assign second_o       = pipe_q[NUM_STAGES-1].second;
  assign sub_second_o   = pipe_q[NUM_STAGES-1].sub_second;

`ifndef SYNTH
  // An accepted word always lands in the first stage.
  a_accept_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> valid_q[0])
    else $error("accepted word did not enter the pipeline");

  // The first stage, when full and its successor does not load, must keep its word.
  a_stage_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q[0] && !load[1] |=> valid_q[0])
    else $error("first stage dropped a stalled word");

  // The date arithmetic only ever yields a month of 1..12 and a day of month of at least 1.
  a_date_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> month_o >= 4'd1 && month_o <= 4'd12
                    && day_of_month_o >= 5'd1)
    else $error("month or day out of range");

  // The time split only ever yields a real clock reading.
  a_time_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> hour_o < 5'd24 && minute_o < 6'd60 && second_o < 6'd60)
    else $error("time of day out of range");
`endif

endmodule
